### sv/mftt_pkg.sv
// Shared constants, register codes and types of the multi-turn tracker.
package mftt_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int IDX_W      = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  localparam int ID_W    = 11;
  localparam int ANGLE_W = 16;
  localparam int CNT_W   = 8;
  localparam int CUR_W   = 14;
  localparam int CFG_W   = 11;

  // One encoder turn is 8192 counts; a step larger than half a turn is a wrap.
  localparam int TURN_SHIFT = 13;
  localparam logic signed [ANGLE_W:0] JUMP_POS = 17'sd4096;
  localparam logic signed [ANGLE_W:0] JUMP_NEG = -17'sd4096;

  // x / 5 == (x * 52429) >> 18 for every 16-bit unsigned x.
  localparam logic [15:0] DIV5_RECIP = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  localparam logic [ID_W-1:0]  BASE_ID_RST     = 11'd513;
  localparam logic [CNT_W-1:0] CALIB_FRAMES_RST = 8'd51;
  localparam logic [CNT_W-1:0] CNT_MAX          = 8'hFF;

  typedef enum logic [0:0] {
    REG_BASE_ID      = 1'b0,
    REG_CALIB_FRAMES = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic               matched;
    logic [1:0]         motor_index;
    logic               calibrating;
    logic signed [31:0] round_count;
    logic signed [31:0] multi_turn_pos;
  } track_result_t;

endpackage

### sv/mftt_if.sv
// Channel interfaces: feedback frame input, result output and configuration writes.
interface mftt_in_if;
  logic                              valid;
  logic                              ready;
  logic [mftt_pkg::ID_W-1:0]         frame_id;
  logic [mftt_pkg::ANGLE_W-1:0]      angle_raw;
  logic signed [15:0]                speed_raw;
  logic signed [15:0]                current_raw;
  logic [7:0]                        temp_raw;

  modport source (output valid, frame_id, angle_raw, speed_raw, current_raw, temp_raw,
                  input ready);
  modport sink   (input valid, frame_id, angle_raw, speed_raw, current_raw, temp_raw,
                  output ready);
endinterface

interface mftt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              matched;
  logic [1:0]                        motor_index;
  logic                              calibrating;
  logic [mftt_pkg::ANGLE_W-1:0]      angle_out;
  logic signed [15:0]                speed_out;
  logic signed [mftt_pkg::CUR_W-1:0] current_scaled;
  logic [7:0]                        temp_out;
  logic signed [31:0]                round_count;
  logic signed [31:0]                multi_turn_pos;

  modport source (output valid, matched, motor_index, calibrating, angle_out, speed_out,
                  current_scaled, temp_out, round_count, multi_turn_pos,
                  input ready);
  modport sink   (input valid, matched, motor_index, calibrating, angle_out, speed_out,
                  current_scaled, temp_out, round_count, multi_turn_pos,
                  output ready);
endinterface

interface mftt_cfg_if;
  logic                         valid;
  logic                         ready;
  mftt_pkg::reg_index_t         reg_index;
  logic [mftt_pkg::CFG_W-1:0]   data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

### sv/mftt_track.sv
// Per-motor calibration and round tracking state with its combinational update logic.
module mftt_track (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [mftt_pkg::ID_W-1:0]     frame_id,
  input  logic [mftt_pkg::ANGLE_W-1:0]  angle,
  input  logic [mftt_pkg::ID_W-1:0]     base_id,
  input  logic [mftt_pkg::CNT_W-1:0]    calib_frames,
  output mftt_pkg::track_result_t       result
);
  import mftt_pkg::*;

  logic [CNT_W-1:0]   frame_count_r [NUM_MOTORS];
  logic [ANGLE_W-1:0] last_angle_r  [NUM_MOTORS];
  logic [ANGLE_W-1:0] offset_r      [NUM_MOTORS];
  logic [31:0]        round_r       [NUM_MOTORS];

  logic [ID_W:0]             id_diff;
  logic                      hit;
  logic [IDX_W-1:0]          idx;
  logic [CNT_W-1:0]          cnt_cur;
  logic                      calib;
  logic signed [ANGLE_W:0]   delta;
  logic [31:0]               round_nxt;
  logic [ANGLE_W-1:0]        offset_nxt;
  logic [CNT_W-1:0]          cnt_nxt;
  logic [31:0]               total;

  always_comb begin
    // The borrow bit of the subtraction flags an identifier below the base.
    id_diff = {1'b0, frame_id} - {1'b0, base_id};
    hit     = !id_diff[ID_W] && (id_diff[ID_W-1:0] < ID_W'(NUM_MOTORS));
    idx     = id_diff[IDX_W-1:0];

    cnt_cur = frame_count_r[idx];
    calib   = cnt_cur < calib_frames;
    cnt_nxt = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
    delta   = $signed({1'b0, angle}) - $signed({1'b0, last_angle_r[idx]});

    round_nxt = round_r[idx];
    if (!calib) begin
      if (delta > JUMP_POS) begin
        round_nxt = round_r[idx] - 32'd1;
      end else if (delta < JUMP_NEG) begin
        round_nxt = round_r[idx] + 32'd1;
      end
    end
    offset_nxt = calib ? angle : offset_r[idx];
    total = {round_nxt[31-TURN_SHIFT:0], {TURN_SHIFT{1'b0}}}
            + 32'(angle) - 32'(offset_nxt);

    result = '0;
    if (hit) begin
      result.matched        = 1'b1;
      result.motor_index    = 2'(idx);
      result.calibrating    = calib;
      result.round_count    = round_nxt;
      result.multi_turn_pos = total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        frame_count_r[m] <= '0;
        last_angle_r[m]  <= '0;
        offset_r[m]      <= '0;
        round_r[m]       <= '0;
      end
    end else if (step && hit) begin
      frame_count_r[idx] <= cnt_nxt;
      last_angle_r[idx]  <= angle;
      offset_r[idx]      <= offset_nxt;
      round_r[idx]       <= round_nxt;
    end
  end

endmodule

### sv/motor_feedback_multi_turn_tracker.sv
// Top level of the multi-turn tracker: handshake, configuration and result register.
// The block takes one feedback frame per clock while the output does not stall, and
// answers each with exactly one result beat: the frame lands in an input register, and
// when it advances the motor's stored state is read, updated and written back while the
// result register is loaded, which then offers the result until it is taken. Frames for
// the same motor may follow each other back to back, since the state write and the result
// load share one edge. A result waiting on a stalled output does not block the next frame
// from entering the input register. Configuration writes are always taken (cfg ready is
// tied high) and should be issued only while the block is idle.
module motor_feedback_multi_turn_tracker (
  input  logic       clk,
  input  logic       rst_n,
  mftt_in_if.sink    in_ch,
  mftt_out_if.source out_ch,
  mftt_cfg_if.sink   cfg_ch
);
  import mftt_pkg::*;

  logic [ID_W-1:0]  base_id_r;
  logic [CNT_W-1:0] calib_frames_r;

  logic                s1_valid_r;
  logic [ID_W-1:0]     s1_frame_id_r;
  logic [ANGLE_W-1:0]  s1_angle_r;
  logic signed [15:0]  s1_speed_r;
  logic signed [15:0]  s1_current_r;
  logic [7:0]          s1_temp_r;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  track_result_t          out_res_r;
  logic [ANGLE_W-1:0]     out_angle_r;
  logic signed [15:0]     out_speed_r;
  logic signed [CUR_W-1:0] out_current_r;
  logic [7:0]             out_temp_r;

  logic                    advance;
  logic                    in_take;
  track_result_t           res;
  logic [15:0]             cur_mag;
  logic [31:0]             cur_prod;
  logic [CUR_W-1:0]        cur_q;
  logic signed [CUR_W-1:0] given;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r      <= BASE_ID_RST;
      calib_frames_r <= CALIB_FRAMES_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_BASE_ID:      base_id_r      <= cfg_ch.data;
        REG_CALIB_FRAMES: calib_frames_r <= cfg_ch.data[CNT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take || (s1_valid_r && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_frame_id_r <= in_ch.frame_id;
      s1_angle_r    <= in_ch.angle_raw;
      s1_speed_r    <= in_ch.speed_raw;
      s1_current_r  <= in_ch.current_raw;
      s1_temp_r     <= in_ch.temp_raw;
    end
  end

  mftt_track u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .frame_id     (s1_frame_id_r),
    .angle        (s1_angle_r),
    .base_id      (base_id_r),
    .calib_frames (calib_frames_r),
    .result       (res)
  );

  // Division by minus five: divide the magnitude by five, then flip the sign.
  always_comb begin
    cur_mag  = s1_current_r[15] ? 16'(-s1_current_r) : 16'(s1_current_r);
    cur_prod = 32'(cur_mag) * 32'(DIV5_RECIP);
    cur_q    = cur_prod[DIV5_SHIFT+CUR_W-1:DIV5_SHIFT];
    given    = s1_current_r[15] ? $signed(cur_q) : -$signed(cur_q);
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pass-through fields read as zero on a beat for an untracked identifier.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r     <= res;
      out_angle_r   <= res.matched ? s1_angle_r : '0;
      out_speed_r   <= res.matched ? s1_speed_r : '0;
      out_current_r <= res.matched ? given : '0;
      out_temp_r    <= res.matched ? s1_temp_r : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.matched        = out_res_r.matched;
  assign out_ch.motor_index    = out_res_r.motor_index;
  assign out_ch.calibrating    = out_res_r.calibrating;
  assign out_ch.angle_out      = out_angle_r;
  assign out_ch.speed_out      = out_speed_r;
  assign out_ch.current_scaled = out_current_r;
  assign out_ch.temp_out       = out_temp_r;
  assign out_ch.round_count    = out_res_r.round_count;
  assign out_ch.multi_turn_pos = out_res_r.multi_turn_pos;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled while a stage was free");

  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.matched) |->
      (out_res_r.round_count == 32'sd0 && out_res_r.multi_turn_pos == 32'sd0 &&
       out_res_r.motor_index == 2'd0 && !out_res_r.calibrating))
    else $error("untracked frame produced nonzero tracking fields");

  a_calib_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.calibrating) |->
      (out_res_r.multi_turn_pos ==
       {out_res_r.round_count[31-TURN_SHIFT:0], {TURN_SHIFT{1'b0}}}))
    else $error("calibration beat total is not a whole number of turns");

  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a frame in the input register");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result changed");

endmodule

### verif/motor_feedback_multi_turn_tracker_test.sv
// Self-checking testbench of the multi-turn tracker: directed frames, random phases, checks.
module motor_feedback_multi_turn_tracker_test;
  import mftt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HALF_TURN   = 4096;
  localparam int TURN_COUNTS = 8192;
  localparam int IDLE_PCT    = 33;

  typedef struct packed {
    logic               matched;
    logic [1:0]         motor;
    logic               calibrating;
    logic [15:0]        angle;
    logic signed [15:0] speed;
    logic signed [13:0] current;
    logic [7:0]         temp;
    logic signed [31:0] turns;
    logic signed [31:0] total;
  } feedback_result_t;

  logic clk;
  logic rst_n;

  mftt_in_if  in_ch ();
  mftt_out_if out_ch ();
  mftt_cfg_if cfg_ch ();

  motor_feedback_multi_turn_tracker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted copy of the configuration and of the per-motor tracking state.
  logic [ID_W-1:0]    cfg_base;
  logic [CNT_W-1:0]   cfg_calib;
  logic [CNT_W-1:0]   seen_frames [NUM_MOTORS];
  logic [15:0]        prev_angle  [NUM_MOTORS];
  logic [15:0]        zero_angle  [NUM_MOTORS];
  logic signed [31:0] turn_count  [NUM_MOTORS];

  feedback_result_t pending_results [$];
  logic [15:0]      sent_angle [NUM_MOTORS];

  bit steady;
  int cycles;
  int mismatches;
  int frames_sent;
  int results_checked;
  int matched_seen;
  int calib_seen;
  int cfg_writes;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic feedback_result_t predict_frame(logic [ID_W-1:0] id,
                                                     logic [15:0] angle,
                                                     logic signed [15:0] speed,
                                                     logic signed [15:0] current,
                                                     logic [7:0] temp);
    feedback_result_t r;
    int slot;
    int jump;
    int quotient;
    r = '0;
    slot = int'(id) - int'(cfg_base);
    if (slot < 0 || slot >= NUM_MOTORS) return r;
    r.calibrating = seen_frames[slot] < cfg_calib;
    if (seen_frames[slot] != CNT_MAX) seen_frames[slot]++;
    if (r.calibrating) begin
      zero_angle[slot] = angle;
    end else begin
      jump = int'(angle) - int'(prev_angle[slot]);
      // A forward wrap counts a turn down, a backward wrap counts one up.
      if (jump > HALF_TURN) turn_count[slot] -= 1;
      else if (jump < -HALF_TURN) turn_count[slot] += 1;
    end
    prev_angle[slot] = angle;
    quotient = int'(current) / -5;
    r.matched = 1'b1;
    r.motor   = slot[1:0];
    r.angle   = angle;
    r.speed   = speed;
    r.current = quotient[13:0];
    r.temp    = temp;
    r.turns   = turn_count[slot];
    r.total   = turn_count[slot] * TURN_COUNTS + int'(angle) - int'(zero_angle[slot]);
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_result();
    feedback_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with nothing expected, expected none, actual total %0h",
               $time, out_ch.multi_turn_pos);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      compare_field("matched", want.matched, out_ch.matched);
      compare_field("motor_index", want.motor, out_ch.motor_index);
      compare_field("calibrating", want.calibrating, out_ch.calibrating);
      compare_field("angle_out", want.angle, out_ch.angle_out);
      compare_field("speed_out", want.speed, out_ch.speed_out);
      compare_field("current_scaled", want.current, out_ch.current_scaled);
      compare_field("temp_out", want.temp, out_ch.temp_out);
      compare_field("round_count", want.turns, out_ch.round_count);
      compare_field("multi_turn_pos", want.total, out_ch.multi_turn_pos);
      results_checked++;
      if (want.matched) matched_seen++;
      if (want.calibrating) calib_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(predict_frame(in_ch.frame_id, in_ch.angle_raw,
                                                in_ch.speed_raw, in_ch.current_raw,
                                                in_ch.temp_raw));
      end
    end
  end

  // Called right after an accepted beat or at the start; valid stays high until the
  // next falling edge either loads a new frame or drops it.
  task automatic send_frame(logic [ID_W-1:0] id, logic [15:0] angle,
                            logic signed [15:0] speed, logic signed [15:0] current,
                            logic [7:0] temp);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.frame_id    <= id;
    in_ch.angle_raw   <= angle;
    in_ch.speed_raw   <= speed;
    in_ch.current_raw <= current;
    in_ch.temp_raw    <= temp;
    do @(posedge clk); while (!in_ch.ready);
    frames_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(reg_index_t index, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= index;
    cfg_ch.data      <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (index == REG_BASE_ID) cfg_base = value;
    else cfg_calib = value[CNT_W-1:0];
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(logic [ID_W-1:0] base, logic [CNT_W-1:0] calib);
    wait_drained();
    write_register(REG_BASE_ID, base);
    // Upper data bits are random; only the low byte sets the calibration length.
    write_register(REG_CALIB_FRAMES, {3'($urandom), calib});
  endtask

  task automatic reset_block();
    in_ch.valid       = 1'b0;
    in_ch.frame_id    = '0;
    in_ch.angle_raw   = '0;
    in_ch.speed_raw   = '0;
    in_ch.current_raw = '0;
    in_ch.temp_raw    = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.reg_index  = REG_BASE_ID;
    cfg_ch.data       = '0;
    rst_n             = 1'b0;
    cfg_base  = BASE_ID_RST;
    cfg_calib = CALIB_FRAMES_RST;
    for (int k = 0; k < NUM_MOTORS; k++) begin
      seen_frames[k] = '0;
      prev_angle[k]  = '0;
      zero_angle[k]  = '0;
      turn_count[k]  = '0;
      sent_angle[k]  = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  endtask

  // Mostly plausible encoder motion per motor, with wrap boundaries and some noise frames.
  task automatic random_frames(int count);
    int k;
    int max_k;
    int roll;
    int delta;
    logic [ID_W-1:0] id;
    logic [15:0] angle;
    logic signed [15:0] current;
    for (int i = 0; i < count; i++) begin
      max_k = 2047 - int'(cfg_base);
      if (max_k > NUM_MOTORS - 1) max_k = NUM_MOTORS - 1;
      k = $urandom_range(0, max_k);
      roll = $urandom_range(0, 99);
      if (roll < 5) id = ID_W'($urandom_range(0, 2047));
      else if (roll < 10) id = roll[0] ? cfg_base - 1'b1 : cfg_base + ID_W'(NUM_MOTORS);
      else id = cfg_base + ID_W'(k);
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0: delta = HALF_TURN;
            1: delta = -HALF_TURN;
            2: delta = HALF_TURN + 1;
            default: delta = -HALF_TURN - 1;
          endcase
          angle = 16'(int'(sent_angle[k]) + delta);
        end
        1, 2, 3, 4, 5, 6: begin
          delta = $urandom_range(0, 600) - 300;
          angle = 16'(int'(sent_angle[k]) + delta) & 16'h1FFF;
        end
        7, 8: begin
          delta = $urandom_range(4000, 8191);
          if ($urandom_range(0, 1)) delta = -delta;
          angle = 16'(int'(sent_angle[k]) + delta) & 16'h1FFF;
        end
        default: angle = 16'($urandom);
      endcase
      case ($urandom_range(0, 19))
        0: current = 16'sh8000;
        1: current = 16'sh7FFF;
        2: current = -16'sd1;
        3: current = 16'sd0;
        default: current = 16'($urandom);
      endcase
      send_frame(id, angle, 16'($urandom), current, 8'($urandom));
      if (roll >= 10) sent_angle[k] = angle;
    end
  endtask

  task automatic test_passthrough_and_unmatched();
    send_frame(11'd512, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 8'hFF);
    send_frame(11'd517, 16'h0000, 16'sh8000, 16'sh8000, 8'h00);
    send_frame(11'd0, 16'h5555, 16'sd1, -16'sd1, 8'h55);
    send_frame(11'd2047, 16'hAAAA, -16'sd1, 16'sd1, 8'hAA);
    // Calibration frames with field extremes on the first and last motor.
    send_frame(11'd513, 16'hFFFF, 16'sh8000, 16'sh8000, 8'hFF);
    send_frame(11'd513, 16'h0000, 16'sh7FFF, 16'sh7FFF, 8'h00);
    send_frame(11'd514, 16'd1234, 16'sd0, -16'sd5, 8'h01);
    send_frame(11'd516, 16'd8191, 16'sd100, 16'sd4, 8'h80);
  endtask

  task automatic test_round_boundaries();
    configure(11'd513, 8'd0);
    // Motor 1 is past its calibration at once and tracks from the angle captured earlier.
    send_frame(11'd514, 16'd4096, 16'sd10, 16'sd9, 8'd30);
    send_frame(11'd514, 16'd8193, 16'sd20, -16'sd9, 8'd31);
    send_frame(11'd514, 16'd4097, -16'sd20, 16'sd5, 8'd32);
    send_frame(11'd514, 16'd0, 16'sd0, -16'sd6, 8'd33);
    send_frame(11'd514, 16'd4097, 16'sh7FFF, 16'sh8000, 8'd34);
    send_frame(11'd514, 16'hFFFF, 16'sh8000, 16'sh7FFF, 8'd35);
    send_frame(11'd514, 16'd0, 16'sd1, 16'sd0, 8'd36);
  endtask

  task automatic test_default_tracking();
    configure(BASE_ID_RST, CALIB_FRAMES_RST);
    random_frames(450);
  endtask

  task automatic test_low_extremes();
    configure(11'd0, 8'd0);
    random_frames(300);
  endtask

  task automatic test_high_extremes();
    configure(11'd2047, 8'd255);
    random_frames(250);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 4; p++) begin
      configure(ID_W'($urandom_range(0, 2047)), CNT_W'($urandom_range(0, 255)));
      random_frames(100);
    end
  endtask

  // Raising the calibration length late recalibrates only motors not yet past it;
  // this phase also runs without any idling on either side.
  task automatic test_late_recalibration();
    configure(BASE_ID_RST, 8'd255);
    steady = 1'b1;
    random_frames(350);
    steady = 1'b0;
  endtask

  initial begin
    steady = 1'b0;
    reset_block();
    test_passthrough_and_unmatched();
    test_round_boundaries();
    test_default_tracking();
    test_low_extremes();
    test_high_extremes();
    test_random_settings();
    test_late_recalibration();
    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      mismatches++;
    end
    $display("Sent %0d frames, %0d for tracked motors and %0d of them calibration, over %0d",
             frames_sent, matched_seen, calib_seen, cfg_writes);
    $display("register writes; %0d results compared with %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
